// File: rtl/lsrc_pkg.sv
`timescale 1ns / 1ps
// lsrc_pkg: shared widths, register indexes, gain constant and sideband type
// for the leg slope rotation correction block; no dependencies
package lsrc_pkg;

  localparam int unsigned CORDIC_STAGES_DEF = 24;

  localparam int COORD_W   = 24;  // coordinate and ground height width
  localparam int FL_W      = 23;  // frame length width
  localparam int LEG_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  // cordic formats: reference vector scaled by 2^32, data vector by 2^8
  localparam int REF_FRAC = 32;
  localparam int DAT_FRAC = 8;
  localparam int REF_W    = 59;
  localparam int DAT_W    = 36;

  // gain removal: product with round(2^28 / K), rounded shift by 36
  localparam int GAIN_W    = 28;
  localparam logic [GAIN_W-1:0] INV_GAIN = 28'd163008219;
  localparam int MUL_SPLIT = 18;                          // low part of data word
  localparam int PH_W      = DAT_W - MUL_SPLIT + GAIN_W + 1;
  localparam int PL_W      = MUL_SPLIT + GAIN_W;
  localparam int PSUM_W    = PH_W + MUL_SPLIT;
  localparam int OUT_SHIFT = 36;
  localparam int RES_W     = PSUM_W - OUT_SHIFT - 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_LENGTH = 3'd0,
    CFG_GROUND_0     = 3'd1,
    CFG_GROUND_1     = 3'd2,
    CFG_GROUND_2     = 3'd3,
    CFG_GROUND_3     = 3'd4
  } cfg_index_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [REF_W-1:0]   ref_t;
  typedef logic signed [DAT_W-1:0]   dat_t;

  // per-item data that rides alongside the cordic
  typedef struct packed {
    logic   bypass;  // level ground: pass y and z unrotated
    coord_t x;
    coord_t y;
    coord_t z;
    coord_t pivot;
  } side_t;

endpackage

// File: rtl/lsrc_cordic_pipe.sv
`timescale 1ns / 1ps
// lsrc_cordic_pipe: one register stage per cordic micro-rotation, reference
// vector in vectoring mode, data vector mirrored; depends on lsrc_pkg
module lsrc_cordic_pipe #(
  parameter int unsigned STAGES = lsrc_pkg::CORDIC_STAGES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  lsrc_pkg::side_t in_side,
  input  lsrc_pkg::ref_t in_vx,
  input  lsrc_pkg::ref_t in_vy,
  input  lsrc_pkg::dat_t in_a,
  input  lsrc_pkg::dat_t in_b,
  output logic           out_valid,
  output lsrc_pkg::side_t out_side,
  output lsrc_pkg::dat_t out_a,
  output lsrc_pkg::dat_t out_b
);

  logic            vld_r  [1:STAGES];
  lsrc_pkg::side_t side_r [1:STAGES];
  lsrc_pkg::dat_t  a_r    [1:STAGES];
  lsrc_pkg::dat_t  b_r    [1:STAGES];
  lsrc_pkg::ref_t  vy_r   [1:STAGES-1];
  lsrc_pkg::ref_t  vx_r   [1:STAGES-2];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic            cur_vld;
    lsrc_pkg::side_t cur_side;
    lsrc_pkg::ref_t  cur_vy;
    lsrc_pkg::dat_t  cur_a;
    lsrc_pkg::dat_t  cur_b;
    lsrc_pkg::dat_t  a_nxt;
    lsrc_pkg::dat_t  b_nxt;
    logic            dir_pos;

    if (i == 0) begin : g_first
      assign cur_vld  = in_valid;
      assign cur_side = in_side;
      assign cur_vy   = in_vy;
      assign cur_a    = in_a;
      assign cur_b    = in_b;
    end else begin : g_next
      assign cur_vld  = vld_r[i];
      assign cur_side = side_r[i];
      assign cur_vy   = vy_r[i];
      assign cur_a    = a_r[i];
      assign cur_b    = b_r[i];
    end

    // reference above the axis: turn it clockwise, data counterclockwise
    assign dir_pos = ~cur_vy[lsrc_pkg::REF_W-1];
    assign a_nxt   = dir_pos ? cur_a - (cur_b >>> i) : cur_a + (cur_b >>> i);
    assign b_nxt   = dir_pos ? cur_b + (cur_a >>> i) : cur_b - (cur_a >>> i);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      side_r[i+1] <= cur_side;
      a_r[i+1]    <= a_nxt;
      b_r[i+1]    <= b_nxt;
    end

    // the reference vector is only needed to steer later stages
    if (i < STAGES - 1) begin : g_ref
      lsrc_pkg::ref_t cur_vx;
      lsrc_pkg::ref_t vy_nxt;

      if (i == 0) begin : g_vx_first
        assign cur_vx = in_vx;
      end else begin : g_vx_next
        assign cur_vx = vx_r[i];
      end

      assign vy_nxt = dir_pos ? cur_vy - (cur_vx >>> i) : cur_vy + (cur_vx >>> i);

      always_ff @(posedge clk) begin
        vy_r[i+1] <= vy_nxt;
      end

      if (i < STAGES - 2) begin : g_vx
        lsrc_pkg::ref_t vx_nxt;
        assign vx_nxt = dir_pos ? cur_vx + (cur_vy >>> i) : cur_vx - (cur_vy >>> i);
        always_ff @(posedge clk) begin
          vx_r[i+1] <= vx_nxt;
        end
      end
    end
  end

  assign out_valid = vld_r[STAGES];
  assign out_side  = side_r[STAGES];
  assign out_a     = a_r[STAGES];
  assign out_b     = b_r[STAGES];

endmodule

// File: rtl/leg_slope_rotation_correction.sv
`timescale 1ns / 1ps
// leg_slope_rotation_correction: rotates a foot position's y/z pair about the
// leg's ground contact by the frame slope angle; uses lsrc_pkg, lsrc_cordic_pipe
//
//   channel  | ports                                      | handshake
//   ---------+--------------------------------------------+-----------------------
//   input    | in_leg_index, in_x, in_y, in_z             | start high, busy low
//   result   | out_x, out_y, out_z                        | out_valid, one cycle
//   config   | cfg_index, cfg_wdata                       | cfg_we, no wait
//
// one item can be taken every cycle once out of reset; each item passes the
// input register, one register per cordic micro-rotation, the split gain
// multiply, the rounded sum, and pivot add and saturation into the output register
// reset is synchronous, active low; busy is high only while rst_n is low
// results cannot be held off, so nothing in the pipeline ever stalls
// the user must write registers only while no transfer is in flight; the block does not enforce it
module leg_slope_rotation_correction #(
  parameter int unsigned CORDIC_STAGES = lsrc_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              start,
  output logic                              busy,
  input  logic [lsrc_pkg::LEG_W-1:0]        in_leg_index,
  input  logic signed [lsrc_pkg::COORD_W-1:0] in_x,
  input  logic signed [lsrc_pkg::COORD_W-1:0] in_y,
  input  logic signed [lsrc_pkg::COORD_W-1:0] in_z,
  // result channel
  output logic                              out_valid,
  output logic signed [lsrc_pkg::COORD_W-1:0] out_x,
  output logic signed [lsrc_pkg::COORD_W-1:0] out_y,
  output logic signed [lsrc_pkg::COORD_W-1:0] out_z,
  // configuration port
  input  logic                              cfg_we,
  input  logic [lsrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lsrc_pkg::CFG_DAT_W-1:0]    cfg_wdata
);

  localparam int unsigned LAT = CORDIC_STAGES + 4;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [lsrc_pkg::FL_W-1:0] frame_length_r;
  lsrc_pkg::coord_t          ground_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r <= lsrc_pkg::FL_W'(1024);
      for (int k = 0; k < 4; k++) begin
        ground_r[k] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        lsrc_pkg::CFG_FRAME_LENGTH: frame_length_r <= cfg_wdata[lsrc_pkg::FL_W-1:0];
        lsrc_pkg::CFG_GROUND_0:     ground_r[0]    <= cfg_wdata;
        lsrc_pkg::CFG_GROUND_1:     ground_r[1]    <= cfg_wdata;
        lsrc_pkg::CFG_GROUND_2:     ground_r[2]    <= cfg_wdata;
        lsrc_pkg::CFG_GROUND_3:     ground_r[3]    <= cfg_wdata;
        default: ;  // indexes past the register list are dropped
      endcase
    end
  end

  // the block always takes a transfer once out of reset
  assign busy = ~rst_n;

  // ---------------------------------------------------------------------------
  // stage 0: pivot select, slope difference, cordic start vectors
  // ---------------------------------------------------------------------------
  logic                       in_take;
  logic signed [lsrc_pkg::COORD_W:0] diff;
  logic signed [lsrc_pkg::COORD_W:0] z_rel;
  lsrc_pkg::coord_t           pivot;
  lsrc_pkg::side_t            s0_side_nxt;

  assign in_take = start & ~busy;
  assign pivot   = ground_r[in_leg_index];
  // front minus back height sets the slope
  assign diff    = {ground_r[0][lsrc_pkg::COORD_W-1], ground_r[0]}
                 - {ground_r[2][lsrc_pkg::COORD_W-1], ground_r[2]};
  assign z_rel   = {in_z[lsrc_pkg::COORD_W-1], in_z} - {pivot[lsrc_pkg::COORD_W-1], pivot};

  always_comb begin
    s0_side_nxt.bypass = (diff == '0);
    s0_side_nxt.x      = in_x;
    s0_side_nxt.y      = in_y;
    s0_side_nxt.z      = in_z;
    s0_side_nxt.pivot  = pivot;
  end

  logic            s0_valid_r;
  lsrc_pkg::side_t s0_side_r;
  lsrc_pkg::ref_t  s0_vx_r;
  lsrc_pkg::ref_t  s0_vy_r;
  lsrc_pkg::dat_t  s0_a_r;
  lsrc_pkg::dat_t  s0_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    s0_side_r <= s0_side_nxt;
    s0_vx_r   <= {{(lsrc_pkg::REF_W - lsrc_pkg::FL_W - lsrc_pkg::REF_FRAC){1'b0}},
                  frame_length_r, {lsrc_pkg::REF_FRAC{1'b0}}};
    s0_vy_r   <= {{(lsrc_pkg::REF_W - lsrc_pkg::COORD_W - 1 - lsrc_pkg::REF_FRAC){diff[lsrc_pkg::COORD_W]}},
                  diff, {lsrc_pkg::REF_FRAC{1'b0}}};
    s0_a_r    <= {{(lsrc_pkg::DAT_W - lsrc_pkg::COORD_W - lsrc_pkg::DAT_FRAC){in_y[lsrc_pkg::COORD_W-1]}},
                  in_y, {lsrc_pkg::DAT_FRAC{1'b0}}};
    s0_b_r    <= {{(lsrc_pkg::DAT_W - lsrc_pkg::COORD_W - 1 - lsrc_pkg::DAT_FRAC){z_rel[lsrc_pkg::COORD_W]}},
                  z_rel, {lsrc_pkg::DAT_FRAC{1'b0}}};
  end

  // ---------------------------------------------------------------------------
  // cordic micro-rotations, one per register stage
  // ---------------------------------------------------------------------------
  logic            cr_valid;
  lsrc_pkg::side_t cr_side;
  lsrc_pkg::dat_t  cr_a;
  lsrc_pkg::dat_t  cr_b;

  lsrc_cordic_pipe #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s0_valid_r),
    .in_side   (s0_side_r),
    .in_vx     (s0_vx_r),
    .in_vy     (s0_vy_r),
    .in_a      (s0_a_r),
    .in_b      (s0_b_r),
    .out_valid (cr_valid),
    .out_side  (cr_side),
    .out_a     (cr_a),
    .out_b     (cr_b)
  );

  // ---------------------------------------------------------------------------
  // m1: gain removal multiply, data word split into high (signed) and low
  // (unsigned) halves to keep each multiplier narrow
  // ---------------------------------------------------------------------------
  localparam logic signed [lsrc_pkg::GAIN_W:0] GAIN_S = {1'b0, lsrc_pkg::INV_GAIN};

  logic signed [lsrc_pkg::DAT_W-lsrc_pkg::MUL_SPLIT-1:0] ah;
  logic signed [lsrc_pkg::DAT_W-lsrc_pkg::MUL_SPLIT-1:0] bh;
  logic [lsrc_pkg::MUL_SPLIT-1:0]                        al;
  logic [lsrc_pkg::MUL_SPLIT-1:0]                        bl;

  assign ah = cr_a[lsrc_pkg::DAT_W-1:lsrc_pkg::MUL_SPLIT];
  assign bh = cr_b[lsrc_pkg::DAT_W-1:lsrc_pkg::MUL_SPLIT];
  assign al = cr_a[lsrc_pkg::MUL_SPLIT-1:0];
  assign bl = cr_b[lsrc_pkg::MUL_SPLIT-1:0];

  logic                                m1_valid_r;
  lsrc_pkg::side_t                     m1_side_r;
  logic signed [lsrc_pkg::PH_W-1:0]    m1_pha_r;
  logic signed [lsrc_pkg::PH_W-1:0]    m1_phb_r;
  logic [lsrc_pkg::PL_W-1:0]           m1_pla_r;
  logic [lsrc_pkg::PL_W-1:0]           m1_plb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_valid_r <= 1'b0;
    end else begin
      m1_valid_r <= cr_valid;
    end
  end

  always_ff @(posedge clk) begin
    m1_side_r <= cr_side;
    m1_pha_r  <= ah * GAIN_S;
    m1_phb_r  <= bh * GAIN_S;
    m1_pla_r  <= al * lsrc_pkg::INV_GAIN;
    m1_plb_r  <= bl * lsrc_pkg::INV_GAIN;
  end

  // ---------------------------------------------------------------------------
  // m2: recombine halves, round half up, floor shift by 36
  // ---------------------------------------------------------------------------
  localparam logic signed [lsrc_pkg::PSUM_W-1:0] ROUND_HALF =
    lsrc_pkg::PSUM_W'(1) <<< (lsrc_pkg::OUT_SHIFT - 1);

  logic signed [lsrc_pkg::PSUM_W-1:0] psum_a;
  logic signed [lsrc_pkg::PSUM_W-1:0] psum_b;

  always_comb begin
    psum_a = $signed({m1_pha_r, {lsrc_pkg::MUL_SPLIT{1'b0}}})
           + $signed({{(lsrc_pkg::PSUM_W - lsrc_pkg::PL_W){1'b0}}, m1_pla_r})
           + ROUND_HALF;
    psum_b = $signed({m1_phb_r, {lsrc_pkg::MUL_SPLIT{1'b0}}})
           + $signed({{(lsrc_pkg::PSUM_W - lsrc_pkg::PL_W){1'b0}}, m1_plb_r})
           + ROUND_HALF;
  end

  logic                              m2_valid_r;
  lsrc_pkg::side_t                   m2_side_r;
  logic signed [lsrc_pkg::RES_W-1:0] m2_ry_r;
  logic signed [lsrc_pkg::RES_W-1:0] m2_rz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_valid_r <= 1'b0;
    end else begin
      m2_valid_r <= m1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    m2_side_r <= m1_side_r;
    m2_ry_r   <= psum_a[lsrc_pkg::OUT_SHIFT+lsrc_pkg::RES_W-1:lsrc_pkg::OUT_SHIFT];
    m2_rz_r   <= psum_b[lsrc_pkg::OUT_SHIFT+lsrc_pkg::RES_W-1:lsrc_pkg::OUT_SHIFT];
  end

  // ---------------------------------------------------------------------------
  // m3: shift z back by the pivot, saturate, level-ground bypass
  // ---------------------------------------------------------------------------
  function automatic lsrc_pkg::coord_t sat_coord(input logic signed [lsrc_pkg::RES_W:0] v);
    logic signed [lsrc_pkg::RES_W:0] hi;
    logic signed [lsrc_pkg::RES_W:0] lo;
    hi = (lsrc_pkg::RES_W+1)'(2 ** (lsrc_pkg::COORD_W - 1) - 1);
    lo = -(lsrc_pkg::RES_W+1)'(2 ** (lsrc_pkg::COORD_W - 1));
    if (v > hi) begin
      return lsrc_pkg::coord_t'(hi);
    end else if (v < lo) begin
      return lsrc_pkg::coord_t'(lo);
    end
    return v[lsrc_pkg::COORD_W-1:0];
  endfunction

  logic signed [lsrc_pkg::RES_W:0] ry_ext;
  logic signed [lsrc_pkg::RES_W:0] rz_sum;
  lsrc_pkg::coord_t                out_y_nxt;
  lsrc_pkg::coord_t                out_z_nxt;

  assign ry_ext = {m2_ry_r[lsrc_pkg::RES_W-1], m2_ry_r};
  assign rz_sum = {m2_rz_r[lsrc_pkg::RES_W-1], m2_rz_r}
                + {{(lsrc_pkg::RES_W + 1 - lsrc_pkg::COORD_W){m2_side_r.pivot[lsrc_pkg::COORD_W-1]}},
                   m2_side_r.pivot};

  always_comb begin
    if (m2_side_r.bypass) begin
      out_y_nxt = m2_side_r.y;
      out_z_nxt = m2_side_r.z;
    end else begin
      out_y_nxt = sat_coord(ry_ext);
      out_z_nxt = sat_coord(rz_sum);
    end
  end

  logic             out_valid_r;
  lsrc_pkg::coord_t out_x_r;
  lsrc_pkg::coord_t out_y_r;
  lsrc_pkg::coord_t out_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= m2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_x_r <= m2_side_r.x;
    out_y_r <= out_y_nxt;
    out_z_r <= out_z_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_z     = out_z_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // every result strobe traces back to an input transfer through the full pipeline
  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result strobe without a matching input transfer");

  // x rides the sideband untouched through every stage
  a_x_passes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_x == $past(in_x, LAT)))
    else $error("x coordinate changed in flight");

  // level ground leaves y and z as they came in
  a_level_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    (m2_valid_r && m2_side_r.bypass) |=>
      (out_valid && out_y == $past(m2_side_r.y) && out_z == $past(m2_side_r.z)))
    else $error("level ground bypass altered y or z");

endmodule
